// File: hw/rtl/mec_pkg.sv
package mec_pkg;

  localparam int DATA_W      = 32;
  localparam int ITER_W      = 16;
  localparam int CHAN_W      = 8;
  localparam int LIMIT_RESET = 100;
  localparam int HUE_STEP    = 60;
  localparam int HUE_SPAN    = 360;
  localparam int RAMP_MAX    = 60;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd128;
  localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

  // register index decoded from paddr[2]
  localparam logic REG_ITER_LIMIT = 1'b0;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic              escaped;
  } result_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  typedef logic [RAMP_MAX:0][CHAN_W-1:0] ramp_t;

  // rising edge of one hue sector, rounded to nearest, halves up
  function automatic ramp_t ramp_table();
    ramp_t t;
    for (int i = 0; i <= RAMP_MAX; i++) begin
      t[i] = CHAN_W'((128 * (HUE_STEP - i) + HUE_STEP / 2) / HUE_STEP);
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/mec_mul.sv
module mec_mul (
  input  logic                    clk,
  input  logic signed [31:0]      a,
  input  logic signed [31:0]      b,
  output logic signed [63:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: hw/rtl/mec_seq.sv
module mec_seq #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mec_pkg::DATA_W-1:0]   c_re,
  input  logic signed [mec_pkg::DATA_W-1:0]   c_im,
  input  logic [COUNT_BITS-1:0]               limit,
  input  logic                                out_free,
  output logic                                idle,
  output logic                                result_valid,
  output mec_pkg::result_t                    result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_MXY,
    S_UPD,
    S_DONE
  } state_t;

  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam logic signed [63:0] VMAX = 64'sd2147483647;
  localparam logic signed [63:0] VMIN = -64'sd2147483647 - 64'sd1;

  state_t                            state;
  logic signed [mec_pkg::DATA_W-1:0] x, y, cr, ci;
  logic signed [mec_pkg::DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]                prod, xx, diff;
  logic signed [63:0]                re_sum, im_sum;
  logic [63:0]                       mag;
  logic [COUNT_BITS-1:0]             n;
  logic                              big;
  logic                              escaped;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > VMAX) return VMAX[31:0];
    if (v < VMIN) return VMIN[31:0];
    return v[31:0];
  endfunction

  mec_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // operand select for the shared multiplier: x*x, y*y, x*y in turn
  always_comb begin
    case (state)
      S_MY: begin
        mul_a = y;
        mul_b = y;
      end
      S_MXY: begin
        mul_a = x;
        mul_b = y;
      end
      default: begin
        mul_a = x;
        mul_b = x;
      end
    endcase
  end

  // both squares are non-negative, so the unsigned sum cannot wrap
  assign mag    = $unsigned(xx) + $unsigned(prod);
  assign re_sum = (diff >>> FRAC_BITS) + 64'(cr);
  assign im_sum = (prod >>> (FRAC_BITS - 1)) + 64'(ci);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cr    <= c_re;
            ci    <= c_im;
            x     <= '0;
            y     <= '0;
            n     <= '0;
            state <= S_MX;
          end
        end
        S_MX: begin
          if (n >= limit) begin
            escaped <= 1'b0;
            state   <= S_DONE;
          end else begin
            state <= S_MY;
          end
        end
        S_MY: begin
          xx    <= prod;
          state <= S_MXY;
        end
        S_MXY: begin
          big   <= (mag >> ESC_SHIFT) != 64'd0;
          diff  <= xx - prod;
          state <= S_UPD;
        end
        S_UPD: begin
          if (big) begin
            escaped <= 1'b1;
            state   <= S_DONE;
          end else begin
            x     <= sat32(re_sum);
            y     <= sat32(im_sum);
            n     <= n + 1'b1;
            state <= S_MX;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle              = (state == S_IDLE);
  assign result_valid      = (state == S_DONE) && out_free;
  assign result.iterations = mec_pkg::ITER_W'(n);
  assign result.escaped    = escaped;

endmodule

// File: hw/rtl/mec_colour.sv
module mec_colour (
  input  mec_pkg::result_t result,
  output mec_pkg::rgb_t    rgb
);

  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  localparam mec_pkg::ramp_t RAMP = mec_pkg::ramp_table();

  logic [8:0]                  hue;
  logic [6:0]                  r;
  logic [5:0]                  d;
  logic [mec_pkg::CHAN_W-1:0]  ramp;
  logic                        lit;
  sector_t                     sector;

  assign lit = result.escaped &&
               (result.iterations < mec_pkg::ITER_W'(mec_pkg::HUE_SPAN));
  assign hue = result.iterations[8:0];

  always_comb begin
    if      (hue < 9'd60)  sector = SEC_RY;
    else if (hue < 9'd120) sector = SEC_YG;
    else if (hue < 9'd180) sector = SEC_GC;
    else if (hue < 9'd240) sector = SEC_CB;
    else if (hue < 9'd300) sector = SEC_BM;
    else                   sector = SEC_MR;
  end

  // hue mod 120, then distance from the middle of the double sector
  always_comb begin
    if      (hue < 9'd120) r = hue[6:0];
    else if (hue < 9'd240) r = 7'(hue - 9'd120);
    else                   r = 7'(hue - 9'd240);
    if (r >= 7'd60) d = 6'(r - 7'd60);
    else            d = 6'(7'd60 - r);
  end

  assign ramp = RAMP[d];

  always_comb begin
    rgb = '{blue: mec_pkg::CHAN_ZERO, green: mec_pkg::CHAN_ZERO, red: mec_pkg::CHAN_ZERO};
    if (lit) begin
      case (sector)
        SEC_RY: begin
          rgb.red   = mec_pkg::CHAN_FULL;
          rgb.green = ramp;
        end
        SEC_YG: begin
          rgb.red   = ramp;
          rgb.green = mec_pkg::CHAN_FULL;
        end
        SEC_GC: begin
          rgb.green = mec_pkg::CHAN_FULL;
          rgb.blue  = ramp;
        end
        SEC_CB: begin
          rgb.green = ramp;
          rgb.blue  = mec_pkg::CHAN_FULL;
        end
        SEC_BM: begin
          rgb.red   = ramp;
          rgb.blue  = mec_pkg::CHAN_FULL;
        end
        default: begin
          rgb.red   = mec_pkg::CHAN_FULL;
          rgb.blue  = ramp;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/mandelbrot_escape_colorizer.sv
// channel   dir  fields (lsb first)
// s_axis    in   tdata: c_real[31:0], c_imag[63:32]
// m_axis    out  tdata: iterations[15:0], escaped[16], red[24:17], green[32:25],
//                blue[40:33], zero[47:41]
// apb       in   iteration_limit at byte address 0
//
// for each iteration of a point, the one 32x32 multiplier forms x*x, y*y and x*y in
// turn, then the update is made
// s_axis_tready is high only while the sequencer is idle
// a finished result sits in the output register; the next point is taken meanwhile
// reset (rst, synchronous) sets the limit to 100 and empties the output register
module mandelbrot_escape_colorizer #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // c_real, c_imag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // iterations, escaped, red, green, blue
);

  logic [COUNT_BITS-1:0] limit;
  logic                  out_free;
  logic                  result_valid;
  mec_pkg::result_t      result;
  mec_pkg::rgb_t         rgb;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mec_pkg::REG_ITER_LIMIT) ? 32'(limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= COUNT_BITS'(mec_pkg::LIMIT_RESET);
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mec_pkg::REG_ITER_LIMIT) begin
      limit <= COUNT_BITS'(pwdata[15:0]);
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  mec_seq #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (s_axis_tvalid),
    .c_re         (s_axis_tdata[31:0]),
    .c_im         (s_axis_tdata[63:32]),
    .limit        (limit),
    .out_free     (out_free),
    .idle         (s_axis_tready),
    .result_valid (result_valid),
    .result       (result)
  );

  mec_colour u_colour (
    .result (result),
    .rgb    (rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (result_valid) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {7'd0, rgb.blue, rgb.green, rgb.red,
                        result.escaped, result.iterations};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/mec_checker.sv
module mec_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic [15:0] iters;
  logic        esc;
  logic [7:0]  red, green, blue;
  logic        black;

  assign iters = m_axis_tdata[15:0];
  assign esc   = m_axis_tdata[16];
  assign red   = m_axis_tdata[24:17];
  assign green = m_axis_tdata[32:25];
  assign blue  = m_axis_tdata[40:33];
  assign black = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);

  // held result stays put while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the iteration loop is busy right after taking a point
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready straight after accepting a point");

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !esc |-> black)
    else $error("inside point not black");

  a_wrap_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && esc && iters >= 16'd360 |-> black)
    else $error("count past hue range not black");

  a_one_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && esc && iters < 16'd360 |->
      (red == 8'd128 || green == 8'd128 || blue == 8'd128))
    else $error("no channel at full value");

endmodule

bind mandelbrot_escape_colorizer mec_checker u_mec_checker (.*);
